@@ sv/thai_mark_reorder_macros.svh @@
// Assertion macros shared by the mark reorder RTL.
// Expects clk_i and rst_ni in the scope of every use.
`ifndef THAI_MARK_REORDER_MACROS_SVH
`define THAI_MARK_REORDER_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define TMR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define TMR_ASSERT_NEXT(lbl, ante, cons, msg) \
  `TMR_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

@@ sv/tmr_pkg.sv @@
// Types, constants and the level lookup for the Thai mark reorder block.
// No dependencies; used by every module of the block.
`default_nettype none

package tmr_pkg;

  typedef enum logic [1:0] {
    LvBase  = 2'd0,
    LvBelow = 2'd1,
    LvAbove = 2'd2,
    LvTop   = 2'd3
  } tmr_level_e;

  localparam logic [7:0] MarkStart = 8'hD0;
  localparam int unsigned LevelEntries = 48;

  localparam tmr_level_e LevelTable [LevelEntries] = '{
    LvBase,  LvAbove, LvBase,  LvBase,  LvAbove, LvAbove, LvAbove, LvAbove,
    LvBelow, LvBelow, LvBelow, LvBase,  LvBase,  LvBase,  LvBase,  LvBase,
    LvBase,  LvBase,  LvBase,  LvBase,  LvBase,  LvBase,  LvBase,  LvAbove,
    LvTop,   LvTop,   LvTop,   LvTop,   LvTop,   LvAbove, LvTop,   LvBase,
    LvBase,  LvBase,  LvBase,  LvBase,  LvBase,  LvBase,  LvBase,  LvBase,
    LvBase,  LvBase,  LvBase,  LvBase,  LvBelow, LvBelow, LvBase,  LvBase
  };

  // Slot positions in a job's output mask, in emission order.
  localparam int unsigned SlotBase  = 0;
  localparam int unsigned SlotBelow = 1;
  localparam int unsigned SlotAbove = 2;
  localparam int unsigned SlotTop   = 3;
  localparam int unsigned SlotTerm  = 4;
  localparam int unsigned NumSlots  = 5;

  typedef logic [NumSlots-1:0] tmr_mask_t;

  typedef struct packed {
    logic [7:0] base;
    logic [7:0] below;
    logic [7:0] above;
    logic [7:0] top;
    tmr_mask_t  mask;
  } tmr_job_t;

  function automatic tmr_level_e level_of(input logic [7:0] b);
    logic [7:0] off;
    off = b - MarkStart;
    if (b > MarkStart) begin
      return LevelTable[off[5:0]];
    end
    return LvBase;
  endfunction

endpackage

`default_nettype wire

@@ sv/tmr_front.sv @@
// Front end: classifies each byte and keeps the open cluster.
// Hands a finished cluster to the job queue. Depends on tmr_pkg.
`default_nettype none
`include "thai_mark_reorder_macros.svh"

module tmr_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  input  wire logic [7:0]      in_byte_i,
  output logic                 job_valid_o,
  output tmr_pkg::tmr_job_t    job_o
);

  logic [7:0] base_q, base_d;
  logic [7:0] below_q, below_d;
  logic [7:0] above_q, above_d;
  logic [7:0] top_q, top_d;
  tmr_pkg::tmr_level_e lev;
  logic has_base;
  logic is_end;

  assign has_base = (base_q != 8'h00);
  assign is_end   = (in_byte_i == 8'h00);
  assign lev      = tmr_pkg::level_of(in_byte_i);

  always_comb begin
    job_o.base  = base_q;
    job_o.below = below_q;
    job_o.above = above_q;
    job_o.top   = top_q;
    job_o.mask  = '0;
    job_o.mask[tmr_pkg::SlotBase]  = has_base;
    job_o.mask[tmr_pkg::SlotBelow] = has_base && (below_q != 8'h00);
    job_o.mask[tmr_pkg::SlotAbove] = has_base && (above_q != 8'h00);
    job_o.mask[tmr_pkg::SlotTop]   = has_base && (top_q != 8'h00);
    job_o.mask[tmr_pkg::SlotTerm]  = is_end;
  end

  always_comb begin
    base_d      = base_q;
    below_d     = below_q;
    above_d     = above_q;
    top_d       = top_q;
    job_valid_o = 1'b0;
    if (in_valid_i) begin
      if (is_end) begin
        job_valid_o = 1'b1;
        base_d      = 8'h00;
        below_d     = 8'h00;
        above_d     = 8'h00;
        top_d       = 8'h00;
      end else begin
        unique case (lev)
          tmr_pkg::LvBase: begin
            job_valid_o = has_base;
            base_d      = in_byte_i;
            below_d     = 8'h00;
            above_d     = 8'h00;
            top_d       = 8'h00;
          end
          tmr_pkg::LvBelow: begin
            if (has_base) below_d = in_byte_i;
          end
          tmr_pkg::LvAbove: begin
            if (has_base) above_d = in_byte_i;
          end
          tmr_pkg::LvTop: begin
            if (has_base) top_d = in_byte_i;
          end
          default: begin
            base_d = base_q;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= 8'h00;
      below_q <= 8'h00;
      above_q <= 8'h00;
      top_q   <= 8'h00;
    end else begin
      base_q  <= base_d;
      below_q <= below_d;
      above_q <= above_d;
      top_q   <= top_d;
    end
  end

  `TMR_ASSERT(a_marks_need_base,
    ((below_q != 8'h00) || (above_q != 8'h00) || (top_q != 8'h00)) |-> (base_q != 8'h00),
    "mark held without a base")

endmodule

`default_nettype wire

@@ sv/tmr_job_fifo.sv @@
// Short job queue between the front end and the output sequencer.
// Register based, one read port. Depends on tmr_pkg.
`default_nettype none
`include "thai_mark_reorder_macros.svh"

module tmr_job_fifo #(
  parameter int unsigned Depth = 4
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  tmr_pkg::tmr_job_t      wdata_i,
  output logic                   full_o,
  input  wire logic              pop_i,
  output logic                   empty_o,
  output tmr_pkg::tmr_job_t      rdata_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  tmr_pkg::tmr_job_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    if (do_pop)  rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    if (do_push && !do_pop) count_d = count_q + 1'b1;
    if (do_pop && !do_push) count_d = count_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= wdata_i;
  end

  `TMR_ASSERT(a_count_bound, count_q <= CntW'(Depth), "job count beyond depth")

endmodule

`default_nettype wire

@@ sv/tmr_back.sv @@
// Output sequencer: walks a job's mask into the output register one beat per
// cycle while that register is empty or being popped. Depends on tmr_pkg.
`default_nettype none
`include "thai_mark_reorder_macros.svh"

module tmr_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              job_empty_i,
  input  tmr_pkg::tmr_job_t      job_i,
  output logic                   job_pop_o,
  output logic                   empty_o,
  input  wire logic              pop_i,
  output logic [7:0]             out_byte_o,
  output logic                   run_last_o
);

  tmr_pkg::tmr_job_t cur_q, cur_d;
  tmr_pkg::tmr_mask_t rem_q, rem_d;
  tmr_pkg::tmr_mask_t sel;
  tmr_pkg::tmr_mask_t rem_next;
  logic [7:0] sel_byte;
  logic out_valid_q, out_valid_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic run_last_q, run_last_d;
  logic adv, emit, done;

  always_comb begin
    sel      = '0;
    sel_byte = 8'h00;
    if (rem_q[tmr_pkg::SlotBase]) begin
      sel[tmr_pkg::SlotBase] = 1'b1;
      sel_byte = cur_q.base;
    end else if (rem_q[tmr_pkg::SlotBelow]) begin
      sel[tmr_pkg::SlotBelow] = 1'b1;
      sel_byte = cur_q.below;
    end else if (rem_q[tmr_pkg::SlotAbove]) begin
      sel[tmr_pkg::SlotAbove] = 1'b1;
      sel_byte = cur_q.above;
    end else if (rem_q[tmr_pkg::SlotTop]) begin
      sel[tmr_pkg::SlotTop] = 1'b1;
      sel_byte = cur_q.top;
    end else if (rem_q[tmr_pkg::SlotTerm]) begin
      sel[tmr_pkg::SlotTerm] = 1'b1;
      sel_byte = 8'h00;
    end
  end

  assign rem_next  = rem_q & ~sel;
  assign adv       = !out_valid_q || pop_i;
  assign emit      = adv && (rem_q != '0);
  assign done      = (rem_q == '0) || (emit && (rem_next == '0));
  assign job_pop_o = done && !job_empty_i;

  always_comb begin
    cur_d       = cur_q;
    rem_d       = rem_q;
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    run_last_d  = run_last_q;
    if (emit) begin
      rem_d       = rem_next;
      out_valid_d = 1'b1;
      out_byte_d  = sel_byte;
      run_last_d  = (rem_next == '0);
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end
    if (job_pop_o) begin
      cur_d = job_i;
      rem_d = job_i.mask;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    out_byte_q <= out_byte_d;
    run_last_q <= run_last_d;
  end

  assign empty_o    = !out_valid_q;
  assign out_byte_o = out_byte_q;
  assign run_last_o = run_last_q;

  `TMR_ASSERT_NEXT(a_job_has_work, job_pop_o, rem_q != '0, "loaded job without beats")
  `TMR_ASSERT(a_term_is_last, (out_valid_q && (out_byte_q == 8'h00)) |-> run_last_q,
    "terminator beat not marked last")

endmodule

`default_nettype wire

@@ sv/thai_mark_reorder.sv @@
// Thai mark reorder, top level. An input byte is taken in any cycle in which
// the job queue has room (push with full low), so bytes enter at one per cycle.
// A base byte or a word end closes the held cluster into a job of up to five
// beats (base, below, above, top, terminator). The output sequencer issues one
// beat per cycle while its output register is empty or popped, and so sets the
// sustained rate. JobDepth clusters can wait between the two sides. A job is
// queued, loaded into the sequencer's job register, then issued beat by beat.
// Depends on tmr_pkg, tmr_front, tmr_job_fifo and tmr_back.
`default_nettype none

module thai_mark_reorder #(
  parameter int unsigned JobDepth = 4
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] in_byte_i,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      out_byte_o,
  output logic            run_last_o
);

  tmr_pkg::tmr_job_t front_job;
  tmr_pkg::tmr_job_t queue_job;
  logic front_job_valid;
  logic queue_empty;
  logic queue_pop;
  logic accept;

  assign accept = push && !full;

  tmr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (accept),
    .in_byte_i   (in_byte_i),
    .job_valid_o (front_job_valid),
    .job_o       (front_job)
  );

  tmr_job_fifo #(
    .Depth (JobDepth)
  ) u_job_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_job_valid),
    .wdata_i (front_job),
    .full_o  (full),
    .pop_i   (queue_pop),
    .empty_o (queue_empty),
    .rdata_o (queue_job)
  );

  tmr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_empty_i (queue_empty),
    .job_i       (queue_job),
    .job_pop_o   (queue_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .out_byte_o  (out_byte_o),
    .run_last_o  (run_last_o)
  );

endmodule

`default_nettype wire

@@ verif/thai_mark_reorder_tb.sv @@
// Testbench for thai_mark_reorder: drives TIS-620 bytes through the push side
// and checks every popped beat against a cluster reorder predictor of its own.
// Depends on tmr_pkg for the level type and the start of the mark table.
`default_nettype none

module thai_mark_reorder_tb;

  localparam int unsigned RandomItems = 435;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned DrainCycles = 20;

  localparam tmr_pkg::tmr_level_e MarkLevels [48] = '{
    tmr_pkg::LvBase,  tmr_pkg::LvAbove, tmr_pkg::LvBase,  tmr_pkg::LvBase,
    tmr_pkg::LvAbove, tmr_pkg::LvAbove, tmr_pkg::LvAbove, tmr_pkg::LvAbove,
    tmr_pkg::LvBelow, tmr_pkg::LvBelow, tmr_pkg::LvBelow, tmr_pkg::LvBase,
    tmr_pkg::LvBase,  tmr_pkg::LvBase,  tmr_pkg::LvBase,  tmr_pkg::LvBase,
    tmr_pkg::LvBase,  tmr_pkg::LvBase,  tmr_pkg::LvBase,  tmr_pkg::LvBase,
    tmr_pkg::LvBase,  tmr_pkg::LvBase,  tmr_pkg::LvBase,  tmr_pkg::LvAbove,
    tmr_pkg::LvTop,   tmr_pkg::LvTop,   tmr_pkg::LvTop,   tmr_pkg::LvTop,
    tmr_pkg::LvTop,   tmr_pkg::LvAbove, tmr_pkg::LvTop,   tmr_pkg::LvBase,
    tmr_pkg::LvBase,  tmr_pkg::LvBase,  tmr_pkg::LvBase,  tmr_pkg::LvBase,
    tmr_pkg::LvBase,  tmr_pkg::LvBase,  tmr_pkg::LvBase,  tmr_pkg::LvBase,
    tmr_pkg::LvBase,  tmr_pkg::LvBase,  tmr_pkg::LvBase,  tmr_pkg::LvBase,
    tmr_pkg::LvBelow, tmr_pkg::LvBelow, tmr_pkg::LvBase,  tmr_pkg::LvBase
  };

  typedef struct {
    logic [7:0] ch;
    logic       is_last;
  } out_beat_t;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       push;
  logic       full;
  logic [7:0] in_byte_i;
  logic       empty;
  logic       pop;
  logic [7:0] out_byte_o;
  logic       run_last_o;

  logic [7:0]  clu_base, clu_below, clu_above, clu_top;
  out_beat_t   pending_beats [$];
  bit          no_gaps;
  int unsigned cycles;
  int unsigned errors;
  int unsigned items_in;
  int unsigned items_live;
  int unsigned beats_checked;
  int unsigned words_sent;

  thai_mark_reorder i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_byte_i  (in_byte_i),
    .empty      (empty),
    .pop        (pop),
    .out_byte_o (out_byte_o),
    .run_last_o (run_last_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
  end

  function automatic tmr_pkg::tmr_level_e mark_level(input logic [7:0] b);
    logic [7:0] off;
    off = b - tmr_pkg::MarkStart;
    if (b > tmr_pkg::MarkStart) begin
      return MarkLevels[off[5:0]];
    end
    return tmr_pkg::LvBase;
  endfunction

  // Emit the held cluster in canonical order and clear it.
  function automatic void flush_cluster(ref out_beat_t beats [$]);
    if (clu_base != 8'h00) begin
      beats.push_back('{clu_base, 1'b0});
      if (clu_below != 8'h00) beats.push_back('{clu_below, 1'b0});
      if (clu_above != 8'h00) beats.push_back('{clu_above, 1'b0});
      if (clu_top != 8'h00)   beats.push_back('{clu_top, 1'b0});
    end
    clu_base  = 8'h00;
    clu_below = 8'h00;
    clu_above = 8'h00;
    clu_top   = 8'h00;
  endfunction

  // Returns 0 when the byte is a mark dropped for want of a base.
  function automatic bit predict_reorder(input logic [7:0] b);
    out_beat_t           beats [$];
    tmr_pkg::tmr_level_e lv;
    bit                  live;
    live = 1'b1;
    lv = mark_level(b);
    if (b == 8'h00) begin
      flush_cluster(beats);
      beats.push_back('{8'h00, 1'b0});
    end else if (lv == tmr_pkg::LvBase) begin
      flush_cluster(beats);
      clu_base = b;
    end else if (clu_base != 8'h00) begin
      case (lv)
        tmr_pkg::LvBelow: clu_below = b;
        tmr_pkg::LvAbove: clu_above = b;
        default:          clu_top   = b;
      endcase
    end else begin
      live = 1'b0;
    end
    if (beats.size() > 0) beats[beats.size()-1].is_last = 1'b1;
    foreach (beats[i]) pending_beats.push_back(beats[i]);
    return live;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] rand_mark();
    logic [7:0] b;
    do b = 8'($urandom_range(8'hD1, 8'hFF)); while (mark_level(b) == tmr_pkg::LvBase);
    return b;
  endfunction

  function automatic logic [7:0] rand_base();
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255)); while (mark_level(b) != tmr_pkg::LvBase);
    return b;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    @(negedge clk_i);
    push      = 1'b1;
    in_byte_i = b;
    do @(posedge clk_i); while (full);
    items_in++;
    if (predict_reorder(b)) items_live++;
    if (b == 8'h00) words_sent++;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk_i);
      push = 1'b0;
    end
  endtask

  task automatic send_word(input int unsigned clusters);
    repeat (clusters) begin
      send_byte(rand_base());
      repeat ($urandom_range(0, 4)) send_byte(rand_mark());
    end
    send_byte(8'h00);
  endtask

  task automatic test_marks_without_base();
    send_byte(8'hD1);
    send_byte(8'hD8);
    send_byte(8'hE8);
    send_byte(8'h00);
    send_byte(8'hFD);
    send_byte(8'h00);
  endtask

  task automatic test_field_extremes();
    send_byte(8'hFF);
    send_byte(8'h01);
    send_byte(8'hD0);
    send_byte(8'hFE);
    send_byte(8'h00);
  endtask

  task automatic test_canonical_order();
    send_byte(8'hA1);
    send_byte(8'hEE);
    send_byte(8'hED);
    send_byte(8'hFC);
    send_byte(8'h00);
    send_byte(8'hB5);
    send_byte(8'hE9);
    send_byte(8'hB5);
  endtask

  task automatic test_repeated_level();
    send_byte(8'hD4);
    send_byte(8'hD7);
    send_byte(8'hDA);
    send_byte(8'hD9);
    send_byte(8'hEC);
    send_byte(8'hE8);
    send_byte(8'h00);
  endtask

  task automatic test_random_stream();
    int unsigned r;
    int unsigned target;
    target = items_live + RandomItems;
    no_gaps = 1'b1;
    while (items_live < target) begin
      if (items_live + 360 > target) no_gaps = 1'b0;
      r = $urandom_range(0, 99);
      if (r < 75) begin
        send_word($urandom_range(1, 4));
      end else if (r < 85) begin
        repeat ($urandom_range(1, 3)) send_byte(rand_mark());
        send_word($urandom_range(0, 2));
      end else begin
        repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)));
      end
    end
    send_byte(8'h00);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (pending_beats.size() == 0) begin
        $error("unexpected beat: out_byte 0x%02h run_last %0b", out_byte_o, run_last_o);
        errors++;
      end else begin
        if (out_byte_o !== pending_beats[0].ch) begin
          $error("out_byte: expected 0x%02h, got 0x%02h", pending_beats[0].ch, out_byte_o);
          errors++;
        end
        if (run_last_o !== pending_beats[0].is_last) begin
          $error("run_last: expected %0b, got %0b", pending_beats[0].is_last, run_last_o);
          errors++;
        end
        void'(pending_beats.pop_front());
        beats_checked++;
      end
    end
  end

  initial begin
    int unsigned stall;
    pop = 1'b0;
    stall = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (stall > 0) begin
        pop = 1'b0;
        stall--;
      end else begin
        pop = 1'b1;
        stall = pick_gap();
      end
    end
  end

  initial begin
    wait (cycles >= CycleLimit);
    $display("Timeout after %0d cycles", cycles);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int unsigned waited;
    errors     = 0;
    items_in   = 0;
    items_live = 0;
    no_gaps    = 1'b0;
    clu_base   = 8'h00;
    clu_below  = 8'h00;
    clu_above  = 8'h00;
    clu_top    = 8'h00;
    rst_ni     = 1'b0;
    push       = 1'b0;
    in_byte_i  = 8'h00;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    test_marks_without_base();
    test_field_extremes();
    test_canonical_order();
    test_repeated_level();
    test_random_stream();

    @(negedge clk_i);
    push = 1'b0;
    while (pending_beats.size() != 0) @(posedge clk_i);
    waited = 0;
    while (waited < DrainCycles) begin
      @(posedge clk_i);
      waited++;
    end
    if (pending_beats.size() != 0) begin
      $error("%0d beats never arrived", pending_beats.size());
      errors++;
    end

    $display("Sent %0d bytes (%0d not dropped) in %0d words; checked %0d beats.",
             items_in, items_live, words_sent, beats_checked);
    $display("Covered dropped marks, overwritten levels, empty flushes and back-pressure.");
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
